@@ design/rep_pkg.sv @@
package rep_pkg;

    // protection mode reported with each result
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_OVER     = 2'd1,
        MODE_REDUCED  = 2'd2,
        MODE_RECOVERY = 2'd3
    } prot_mode_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BANK_ANGLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTHORITY_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_RATE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN           = 3'd4;

    // configuration reset values
    localparam logic [14:0]        MAX_REQUEST_RATE_RST    = 15'd7680;
    localparam logic [15:0]        MAX_BANK_ANGLE_RST      = 16'd17152;
    localparam logic [15:0]        AUTHORITY_THRESHOLD_RST = 16'd8448;
    localparam logic signed [15:0] RECOVERY_RATE_RST       = -16'sd2560;
    localparam logic [15:0]        RATE_GAIN_RST           = 16'd4096;

    // aileron command limits, plus and minus full scale (32767) in Q1.15
    localparam logic signed [29:0] CMD_POS_LIMIT = 30'sd32767;
    localparam logic signed [29:0] CMD_NEG_LIMIT = -30'sd32767;

    // pipeline layout
    localparam int DIV_STEPS  = 15;
    localparam int STG_IN     = 0;
    localparam int STG_PREP   = 1;
    localparam int STG_MUL    = 2;
    localparam int STG_DIV0   = 3;
    localparam int STG_SEL    = STG_DIV0 + DIV_STEPS + 1;
    localparam int STG_GAIN   = STG_SEL + 1;
    localparam int PIPE_DEPTH = STG_GAIN + 1;

endpackage

@@ design/rep_in_if.sv @@
interface rep_in_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] bank_angle;
    logic signed [15:0] stick_roll;
    logic signed [15:0] roll_rate;

    modport source (output valid, output bank_angle, output stick_roll, output roll_rate,
                    input ready);
    modport sink (input valid, input bank_angle, input stick_roll, input roll_rate,
                  output ready);
endinterface

@@ design/rep_out_if.sv @@
interface rep_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] aileron_command;
    logic               command_clamped;
    logic [1:0]         protection_mode;

    modport source (output valid, output aileron_command, output command_clamped,
                    output protection_mode, input ready);
    modport sink (input valid, input aileron_command, input command_clamped,
                  input protection_mode, output ready);
endinterface

@@ design/rep_cfg_if.sv @@
interface rep_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/roll_envelope_protection.sv @@
// order: input, prep, multiply, divider set-up, divider, selection, gain, output register
// throughput: one sample per cycle unless a full pipe stalls; the authority bound comes
// from a 15-stage restoring divider, one quotient bit per stage, setting pipeline depth
// a bubble in any stage lets input continue while a finished result waits at the output
// reset: all valid bits clear and the configuration registers load their reset values
module roll_envelope_protection
    import rep_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rep_in_if.sink        sample,
    rep_out_if.source     result,
    rep_cfg_if.sink       cfg
);

    // configuration registers
    logic [14:0]        max_rate_reg;
    logic [15:0]        max_bank_reg;
    logic [15:0]        threshold_reg;
    logic signed [15:0] recovery_reg;
    logic [15:0]        gain_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg  <= MAX_REQUEST_RATE_RST;
            max_bank_reg  <= MAX_BANK_ANGLE_RST;
            threshold_reg <= AUTHORITY_THRESHOLD_RST;
            recovery_reg  <= RECOVERY_RATE_RST;
            gain_reg      <= RATE_GAIN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MAX_REQUEST_RATE:    max_rate_reg  <= cfg.data[14:0];
                CFG_MAX_BANK_ANGLE:      max_bank_reg  <= cfg.data;
                CFG_AUTHORITY_THRESHOLD: threshold_reg <= cfg.data;
                CFG_RECOVERY_RATE:       recovery_reg  <= $signed(cfg.data);
                CFG_RATE_GAIN:           gain_reg      <= cfg.data;
                default:                 ;
            endcase
        end
    end

    // pipeline valid bits and stage enables
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [PIPE_DEPTH:0]   en;
    logic                  out_valid_reg;

    // a stage loads when the output drains or any stage at or after it holds a bubble
    always_comb
    begin
        en[PIPE_DEPTH] = !out_valid_reg || result.ready;
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            en[k] = en[PIPE_DEPTH]
                 || !(&(vld_reg | PIPE_DEPTH'((64'd1 << k) - 64'd1)));
        end
    end

    assign sample.ready = en[STG_IN];
    assign vld_next     = {vld_reg[PIPE_DEPTH-2:0], sample.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
            if (en[PIPE_DEPTH])
            begin
                out_valid_reg <= vld_reg[PIPE_DEPTH-1];
            end
        end
    end

    // input capture
    logic signed [16:0] s0_bank_reg;
    logic signed [15:0] s0_stick_reg;
    logic signed [15:0] s0_rate_reg;

    always_ff @(posedge clk)
    begin
        if (en[STG_IN])
        begin
            s0_bank_reg  <= sample.bank_angle;
            s0_stick_reg <= sample.stick_roll;
            s0_rate_reg  <= sample.roll_rate;
        end
    end

    // bank magnitude, band distance and mode decision
    logic [16:0]        mag;
    logic               band;
    logic               stick_zero;
    prot_mode_t         s1_mode_next;
    logic [15:0]        s1_diff_reg;
    prot_mode_t         s1_mode_reg;
    logic               s1_bneg_reg;
    logic               s1_bzero_reg;
    logic signed [15:0] s1_stick_reg;
    logic signed [15:0] s1_rate_reg;

    always_comb
    begin
        mag        = s0_bank_reg[16] ? 17'(-s0_bank_reg) : 17'(s0_bank_reg);
        band       = mag > {1'b0, threshold_reg};
        stick_zero = (s0_stick_reg == 16'sd0);
        priority if (mag >= {1'b0, max_bank_reg})
            s1_mode_next = MODE_OVER;
        else if (band && !stick_zero && (s0_bank_reg[16] != s0_stick_reg[15]))
            s1_mode_next = MODE_REDUCED;
        else if (band && stick_zero)
            s1_mode_next = MODE_RECOVERY;
        else
            s1_mode_next = MODE_NORMAL;
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_PREP])
        begin
            s1_diff_reg  <= 16'(mag - {1'b0, threshold_reg});
            s1_mode_reg  <= s1_mode_next;
            s1_bneg_reg  <= s0_bank_reg[16];
            s1_bzero_reg <= (s0_bank_reg == 17'sd0);
            s1_stick_reg <= s0_stick_reg;
            s1_rate_reg  <= s0_rate_reg;
        end
    end

    // stick request and bound numerator products
    logic signed [31:0] s2_prod_reg;
    logic [30:0]        s2_num_reg;
    prot_mode_t         s2_mode_reg;
    logic               s2_bneg_reg;
    logic               s2_bzero_reg;
    logic signed [15:0] s2_rate_reg;

    always_ff @(posedge clk)
    begin
        if (en[STG_MUL])
        begin
            s2_prod_reg  <= s1_stick_reg * $signed({1'b0, max_rate_reg});
            s2_num_reg   <= s1_diff_reg * max_rate_reg;
            s2_mode_reg  <= s1_mode_reg;
            s2_bneg_reg  <= s1_bneg_reg;
            s2_bzero_reg <= s1_bzero_reg;
            s2_rate_reg  <= s1_rate_reg;
        end
    end

    // request scaled to Q8.8 toward zero, divider set up
    logic               des_corr;
    logic signed [15:0] s3_des_reg;
    logic [15:0]        s3_rem_reg;
    logic [14:0]        s3_low_reg;
    prot_mode_t         s3_mode_reg;
    logic               s3_bneg_reg;
    logic               s3_bzero_reg;
    logic signed [15:0] s3_rate_reg;

    assign des_corr = s2_prod_reg[31] && (s2_prod_reg[14:0] != 15'd0);

    always_ff @(posedge clk)
    begin
        if (en[STG_DIV0])
        begin
            s3_des_reg   <= 16'(s2_prod_reg >>> 15) + 16'(des_corr);
            s3_rem_reg   <= s2_num_reg[30:15];
            s3_low_reg   <= s2_num_reg[14:0];
            s3_mode_reg  <= s2_mode_reg;
            s3_bneg_reg  <= s2_bneg_reg;
            s3_bzero_reg <= s2_bzero_reg;
            s3_rate_reg  <= s2_rate_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [15:0]        span;
    logic [15:0]        div_rem_reg  [DIV_STEPS];
    logic [14:0]        div_low_reg  [DIV_STEPS];
    logic [14:0]        div_quo_reg  [DIV_STEPS];
    logic signed [15:0] div_des_reg  [DIV_STEPS];
    prot_mode_t         div_mode_reg [DIV_STEPS];
    logic               div_bneg_reg [DIV_STEPS];
    logic               div_bzero_reg[DIV_STEPS];
    logic signed [15:0] div_rate_reg [DIV_STEPS];
    logic [15:0]        div_rem_next [DIV_STEPS];
    logic [14:0]        div_low_next [DIV_STEPS];
    logic [14:0]        div_quo_next [DIV_STEPS];

    assign span = max_bank_reg - threshold_reg;

    always_comb
    begin
        logic [15:0] rem_in;
        logic [14:0] low_in;
        logic [14:0] quo_in;
        logic [16:0] trial;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (j == 0)
            begin
                rem_in = s3_rem_reg;
                low_in = s3_low_reg;
                quo_in = '0;
            end
            else
            begin
                rem_in = div_rem_reg[j-1];
                low_in = div_low_reg[j-1];
                quo_in = div_quo_reg[j-1];
            end
            trial           = {rem_in, low_in[14]};
            div_low_next[j] = {low_in[13:0], 1'b0};
            if (trial >= {1'b0, span})
            begin
                div_rem_next[j] = 16'(trial - {1'b0, span});
                div_quo_next[j] = {quo_in[13:0], 1'b1};
            end
            else
            begin
                div_rem_next[j] = trial[15:0];
                div_quo_next[j] = {quo_in[13:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (en[STG_DIV0+1+j])
            begin
                div_rem_reg[j] <= div_rem_next[j];
                div_low_reg[j] <= div_low_next[j];
                div_quo_reg[j] <= div_quo_next[j];
                if (j == 0)
                begin
                    div_des_reg[j]   <= s3_des_reg;
                    div_mode_reg[j]  <= s3_mode_reg;
                    div_bneg_reg[j]  <= s3_bneg_reg;
                    div_bzero_reg[j] <= s3_bzero_reg;
                    div_rate_reg[j]  <= s3_rate_reg;
                end
                else
                begin
                    div_des_reg[j]   <= div_des_reg[j-1];
                    div_mode_reg[j]  <= div_mode_reg[j-1];
                    div_bneg_reg[j]  <= div_bneg_reg[j-1];
                    div_bzero_reg[j] <= div_bzero_reg[j-1];
                    div_rate_reg[j]  <= div_rate_reg[j-1];
                end
            end
        end
    end

    // desired rate selection and rate error
    logic [14:0]        bound;
    logic [15:0]        dmag;
    logic signed [16:0] rec_wide;
    logic signed [16:0] rec_signed;
    logic signed [15:0] des_in;
    logic signed [16:0] desired;
    logic signed [17:0] s19_err_reg;
    prot_mode_t         s19_mode_reg;

    always_comb
    begin
        des_in     = div_des_reg[DIV_STEPS-1];
        bound      = max_rate_reg - div_quo_reg[DIV_STEPS-1];
        dmag       = des_in[15] ? 16'(-des_in) : 16'(des_in);
        rec_wide   = 17'(recovery_reg);
        priority if (div_bzero_reg[DIV_STEPS-1])
            rec_signed = 17'sd0;
        else if (div_bneg_reg[DIV_STEPS-1])
            rec_signed = -rec_wide;
        else
            rec_signed = rec_wide;
        unique case (div_mode_reg[DIV_STEPS-1])
            MODE_OVER, MODE_RECOVERY:
                desired = rec_signed;
            MODE_REDUCED:
            begin
                if (dmag > {1'b0, bound})
                    desired = des_in[15] ? -$signed({2'b00, bound}) : $signed({2'b00, bound});
                else
                    desired = 17'(des_in);
            end
            default:
                desired = 17'(des_in);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_SEL])
        begin
            s19_err_reg  <= 18'(desired) - 18'(div_rate_reg[DIV_STEPS-1]);
            s19_mode_reg <= div_mode_reg[DIV_STEPS-1];
        end
    end

    // proportional gain
    logic signed [34:0] s20_prod_reg;
    prot_mode_t         s20_mode_reg;

    always_ff @(posedge clk)
    begin
        if (en[STG_GAIN])
        begin
            s20_prod_reg <= $signed({1'b0, gain_reg}) * s19_err_reg;
            s20_mode_reg <= s19_mode_reg;
        end
    end

    // scale to Q1.15 toward zero and clamp into the output register
    logic               cmd_corr;
    logic signed [29:0] cmd_wide;
    logic signed [15:0] ail_next;
    logic               clamp_next;
    logic signed [15:0] ail_reg;
    logic               clamp_reg;
    prot_mode_t         out_mode_reg;

    always_comb
    begin
        cmd_corr = s20_prod_reg[34] && (s20_prod_reg[4:0] != 5'd0);
        cmd_wide = 30'(s20_prod_reg >>> 5) + 30'(cmd_corr);
        priority if (cmd_wide > CMD_POS_LIMIT)
        begin
            ail_next   = 16'(CMD_POS_LIMIT);
            clamp_next = 1'b1;
        end
        else if (cmd_wide < CMD_NEG_LIMIT)
        begin
            ail_next   = 16'(CMD_NEG_LIMIT);
            clamp_next = 1'b1;
        end
        else
        begin
            ail_next   = cmd_wide[15:0];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[PIPE_DEPTH])
        begin
            ail_reg      <= ail_next;
            clamp_reg    <= clamp_next;
            out_mode_reg <= s20_mode_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.aileron_command = ail_reg;
    assign result.command_clamped = clamp_reg;
    assign result.protection_mode = out_mode_reg;

    // an accepted sample always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> vld_reg[STG_IN])
        else $error("accepted sample not captured");

    // input backpressure only when every stage and the output are full
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && (&vld_reg)))
        else $error("input blocked while pipeline has a bubble");

    // a new result comes from the last stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(vld_reg[PIPE_DEPTH-1]))
        else $error("result appeared without a valid last stage");

    // a clamped command sits exactly on a limit
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.command_clamped) |->
            (result.aileron_command == 16'sd32767 || result.aileron_command == -16'sd32767))
        else $error("clamp flag without limit value");

endmodule
